[sv/drle_pkg.sv]
package drle_pkg;

  localparam int VALUE_W     = 31;
  localparam int DIGIT_W     = 4;
  localparam int RUN_LEN_W   = 10;
  localparam int BIT_CNT_W   = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // What the back end is to do with one queue entry
  typedef enum logic [1:0] {
    ENT_DIGIT     = 2'd0,
    ENT_DIGIT_END = 2'd1,
    ENT_FLUSH     = 2'd2
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t         kind;
    logic [DIGIT_W-1:0]  digit;
  } q_entry_t;

  typedef struct packed {
    logic                 final_res;
    logic [RUN_LEN_W-1:0] run_length;
    logic [DIGIT_W-1:0]   digit;
  } pair_t;

endpackage

[sv/drle_front.sv]
module drle_front
  import drle_pkg::*;
#(
  parameter int MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  output logic               push,
  output q_entry_t           push_entry,
  input  logic               push_ready
);

  localparam int BCD_W = DIGIT_W * MAX_DIGITS;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_SCAN = 3'b100
  } front_state_t;

  front_state_t           state, state_next;
  logic [VALUE_W-1:0]     value_sr;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [BCD_W-1:0]       bcd, bcd_adj, bcd_rest;
  logic                   item_last;
  logic                   started;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   rest_nz;

  assign in_ready = (state == F_IDLE);

  // Add three to every digit of five or more before the doubling shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];
  assign bcd_rest  = bcd << DIGIT_W;
  assign rest_nz   = |bcd_rest;

  always_comb begin
    push            = 1'b0;
    push_entry      = '{kind: ENT_DIGIT, digit: top_digit};
    state_next      = state;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = F_CONV;
        end
      end
      F_CONV: begin
        if (bit_cnt == BIT_CNT_W'(1)) begin
          state_next = F_SCAN;
        end
      end
      F_SCAN: begin
        if (bcd == '0) begin
          // no digits in this number
          if (item_last) begin
            push            = 1'b1;
            push_entry.kind = ENT_FLUSH;
            if (push_ready) begin
              state_next = F_IDLE;
            end
          end else begin
            state_next = F_IDLE;
          end
        end else if (started || top_digit != '0) begin
          push = 1'b1;
          if (!rest_nz && item_last) begin
            push_entry.kind = ENT_DIGIT_END;
          end
          if (push_ready && !rest_nz) begin
            state_next = F_IDLE;
          end
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && in_valid) begin
        started <= 1'b0;
      end else if (state == F_SCAN && push && push_ready) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        value_sr  <= in_value;
        bit_cnt   <= BIT_CNT_W'(VALUE_W);
        bcd       <= '0;
        item_last <= in_last;
      end
      F_CONV: begin
        bcd      <= {bcd_adj[BCD_W-2:0], value_sr[VALUE_W-1]};
        value_sr <= value_sr << 1;
        bit_cnt  <= bit_cnt - BIT_CNT_W'(1);
      end
      F_SCAN: begin
        if (bcd != '0 && (!push || push_ready)) begin
          bcd <= bcd_rest;
        end
      end
      default: begin
        bcd <= bcd;
      end
    endcase
  end

endmodule

[sv/drle_queue.sv]
module drle_queue
  import drle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  q_entry_t wr_entry,
  output logic     wr_ready,
  output logic     rd_valid,
  output q_entry_t rd_entry,
  input  logic     rd
);

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr, do_rd;

  assign wr_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_wr    = wr && wr_ready;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

[sv/drle_back.sv]
module drle_back
  import drle_pkg::*;
#(
  parameter int MAX_RUN = 1023
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  q_entry_t q_entry,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output pair_t    out_pair
);

  localparam int CNT_RAW_W = $clog2(MAX_RUN + 1);
  localparam int CW        = (CNT_RAW_W < RUN_LEN_W) ? RUN_LEN_W : CNT_RAW_W;
  localparam logic [CW-1:0] MAX_RUN_C = CW'(MAX_RUN);

  logic [DIGIT_W-1:0] run_digit;
  logic [CW-1:0]      run_count;
  logic               run_open;
  logic               pending;
  pair_t              second;

  logic               out_free;
  logic               same, hit, closing, is_flush;
  logic [CW-1:0]      cnt_inc;
  logic               p1_en, p2_en;
  pair_t              p1, p2;

  assign out_free = !out_valid || out_ready;
  assign is_flush = (q_entry.kind == ENT_FLUSH);
  assign same     = run_open && (run_digit == q_entry.digit);
  assign cnt_inc  = same ? run_count + CW'(1) : CW'(1);
  assign hit      = (cnt_inc >= MAX_RUN_C);
  assign closing  = hit || (q_entry.kind == ENT_DIGIT_END);

  always_comb begin
    p1.digit      = run_digit;
    p1.run_length = run_count[RUN_LEN_W-1:0];
    p1.final_res  = 1'b0;
    if (is_flush) begin
      p1_en         = 1'b0;
      p2_en         = run_open;
      p2.digit      = run_digit;
      p2.run_length = run_count[RUN_LEN_W-1:0];
      p2.final_res  = 1'b1;
    end else begin
      p1_en         = run_open && !same;
      p2_en         = closing;
      p2.digit      = q_entry.digit;
      p2.run_length = cnt_inc[RUN_LEN_W-1:0];
      p2.final_res  = (q_entry.kind == ENT_DIGIT_END);
    end
  end

  assign q_pop = q_valid && out_free && !pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_digit <= '0;
      run_count <= '0;
      run_open  <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pending && out_free) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (q_pop) begin
        if (p1_en || p2_en) begin
          out_valid <= 1'b1;
        end
        pending <= p1_en && p2_en;
        if (is_flush) begin
          run_open  <= 1'b0;
          run_count <= '0;
        end else begin
          run_digit <= q_entry.digit;
          run_open  <= !closing;
          run_count <= closing ? '0 : cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pending && out_free) begin
      out_pair <= second;
    end else if (q_pop) begin
      out_pair <= p1_en ? p1 : p2;
      second   <= p2;
    end
  end

endmodule

[sv/digit_run_length_encoder.sv]
// Channel  Dir  Fields (tdata from bit 0 up)                tlast
// s_*      in   value[30:0], pad[31]                        last
// m_*      out  digit[3:0], run_length[13:4], pad[15:14]    final_res
//
// One number is loaded, converted by shift-and-add-three in the front
// converter and then scanned digit by digit from the most significant
// (up to MAX_DIGITS); the front end takes no new number until it is done.
// The back end handles one queue entry per cycle while m_tready does not
// stall it; an entry that closes a run and ends the number gives two pairs.
// rst is synchronous and active high; it closes any open run and empties
// the queue. A stalled m_tready holds the back end; the queue then fills
// and holds the front end at its next digit.
module digit_run_length_encoder
  import drle_pkg::*;
#(
  parameter int MAX_RUN    = 1023,
  parameter int MAX_DIGITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[30:0], zero[31]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // digit[3:0], run_length[13:4], zero[15:14]
  output logic        m_tlast
);

  logic     push, push_ready;
  q_entry_t push_entry;
  logic     q_valid, q_pop;
  q_entry_t q_entry;
  pair_t    out_pair;

  // Front: convert the number to decimal and push its significant digits
  drle_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .in_last    (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Decouple the digit scan from the run counter
  drle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (push),
    .wr_entry (push_entry),
    .wr_ready (push_ready),
    .rd_valid (q_valid),
    .rd_entry (q_entry),
    .rd       (q_pop)
  );

  // Back: extend or close runs and drive the output register
  drle_back #(
    .MAX_RUN (MAX_RUN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pair  (out_pair)
  );

  assign m_tdata = {2'b00, out_pair.run_length, out_pair.digit};
  assign m_tlast = out_pair.final_res;

endmodule
